### rtl/core/bmf_pkg.sv
// bmf_pkg: shared types, constants and helpers of the 3x3 binary majority filter
// no dependencies
package bmf_pkg;

    localparam int C_MAX_WIDTH = 1024;
    localparam int CFG_W_W = 11;
    localparam int ROW_W = 16;

    localparam logic [CFG_W_W-1:0] C_WIDTH_RST = 11'd1024;
    localparam logic [ROW_W-1:0] C_HEIGHT_RST = 16'd1024;

    typedef enum logic {
        OP_CELL  = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // control of one result on its way from the counters to the window
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       left_ok;
        logic       right_ok;
        logic       top_ok;
        logic       bot_ok;
        logic       first_col;
        logic [1:0] bank;
        logic       byp_hit;
        logic [1:0] byp_bank;
        logic       byp_bit;
    } t_win_ctl;

    // rows base-1, base, base+1 out of four row banks, returned as {bottom, middle, top}
    function automatic logic [2:0] pick3(input logic [3:0] v, input logic [1:0] base);
        logic [1:0] b_top;
        logic [1:0] b_bot;
        b_top = base - 2'd1;
        b_bot = base + 2'd1;
        return {v[b_bot], v[base], v[b_top]};
    endfunction

    function automatic logic [3:0] popcount9(input logic [8:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 9; k++) begin
            n = n + {3'd0, v[k]};
        end
        return n;
    endfunction

endpackage

### rtl/core/bmf_ram.sv
// bmf_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies
module bmf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bmf_ctrl.sv
// bmf_ctrl: input register, configuration registers, raster counters and line store addressing
// depends on bmf_pkg
module bmf_ctrl
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH = C_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_valid,
    input  logic                          i_opcode,
    input  logic                          i_cell_in,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_index,
    input  logic [ROW_W-1:0]              i_cfg_data,
    output logic                          o_ram_we,
    output logic [1:0]                    o_ram_wbank,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_ram_waddr,
    output logic                          o_ram_wdata,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_ram_raddr,
    output logic [3:0]                    o_col0,
    output t_win_ctl                      o_win
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WCNT_W > CFG_W_W) ? WCNT_W : CFG_W_W;

    logic [CFG_W_W-1:0] r_cfg_width;
    logic [ROW_W-1:0]   r_cfg_height;

    logic               r_a_valid;
    t_opcode            r_a_op;
    logic               r_a_cell;

    logic [COL_W-1:0]   r_in_col;
    logic [ROW_W-1:0]   r_in_row;
    logic               r_in_done;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic [3:0]         r_col0;
    t_win_ctl           r_win;

    logic [COL_W-1:0]   n_in_col;
    logic [ROW_W-1:0]   n_in_row;
    logic               n_in_done;
    logic [COL_W-1:0]   n_out_col;
    logic [ROW_W-1:0]   n_out_row;
    t_win_ctl           n_win;

    logic [CW-1:0]      wide_w;
    logic [WCNT_W-1:0]  eff_w;
    logic [ROW_W-1:0]   eff_h;
    logic [ROW_W:0]     eff_h_x;
    logic               wr;
    logic               cfg_hit;
    logic [WCNT_W-1:0]  in_col_p1;
    logic [ROW_W:0]     in_row_p1;
    logic [WCNT_W-1:0]  out_col_p1;
    logic [ROW_W:0]     out_row_p1;
    logic [WCNT_W-1:0]  cn;
    logic [ROW_W:0]     rn;
    logic               ready;
    logic               right_ok;

    // geometry with out-of-range settings folded in
    always_comb begin
        wide_w = CW'(r_cfg_width);
        if (r_cfg_width == '0) begin
            eff_w = WCNT_W'(1);
        end else if (wide_w > CW'(MAX_WIDTH)) begin
            eff_w = WCNT_W'(MAX_WIDTH);
        end else begin
            eff_w = WCNT_W'(wide_w);
        end
        eff_h = (r_cfg_height == '0) ? ROW_W'(1) : r_cfg_height;
        eff_h_x = {1'b0, eff_h};
    end

    always_comb begin
        case (t_reg_idx'(i_cfg_index))
            REG_WIDTH:  cfg_hit = i_cfg_valid;
            REG_HEIGHT: cfg_hit = i_cfg_valid;
            default:    cfg_hit = 1'b0;
        endcase
    end

    assign wr = r_a_valid && (r_a_op == OP_CELL) && !r_in_done;
    assign in_col_p1 = WCNT_W'(r_in_col) + WCNT_W'(1);
    assign in_row_p1 = {1'b0, r_in_row} + 17'd1;
    assign out_col_p1 = WCNT_W'(r_out_col) + WCNT_W'(1);
    assign out_row_p1 = {1'b0, r_out_row} + 17'd1;
    assign right_ok = out_col_p1 < eff_w;

    // input position after this item's write
    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_in_done = r_in_done;
        if (wr) begin
            if (in_col_p1 >= eff_w) begin
                n_in_col = '0;
                if (in_row_p1 >= eff_h_x) begin
                    n_in_row = '0;
                    n_in_done = 1'b1;
                end else begin
                    n_in_row = in_row_p1[ROW_W-1:0];
                end
            end else begin
                n_in_col = in_col_p1[COL_W-1:0];
            end
        end
    end

    // next result may leave once its lower right neighbour is in
    always_comb begin
        cn = right_ok ? out_col_p1 : eff_w - WCNT_W'(1);
        rn = (out_row_p1 < eff_h_x) ? out_row_p1 : eff_h_x - 17'd1;
        ready = r_a_valid && (n_in_done || ({1'b0, n_in_row} > rn)
                || (({1'b0, n_in_row} == rn) && (WCNT_W'(n_in_col) > cn)));
    end

    always_comb begin
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_win = '0;
        n_win.valid = ready;
        n_win.left_ok = (r_out_col != '0);
        n_win.right_ok = right_ok;
        n_win.top_ok = (r_out_row != '0);
        n_win.bot_ok = (out_row_p1 < eff_h_x);
        n_win.first_col = (r_out_col == '0);
        n_win.bank = r_out_row[1:0];
        n_win.byp_hit = wr && right_ok && (WCNT_W'(r_in_col) == out_col_p1);
        n_win.byp_bank = r_in_row[1:0];
        n_win.byp_bit = r_a_cell;
        if (ready) begin
            if (!right_ok) begin
                n_out_col = '0;
                if (out_row_p1 >= eff_h_x) begin
                    n_win.last = 1'b1;
                end else begin
                    n_out_row = out_row_p1[ROW_W-1:0];
                end
            end else begin
                n_out_col = out_col_p1[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= C_WIDTH_RST;
            r_cfg_height <= C_HEIGHT_RST;
            r_a_valid <= 1'b0;
            r_in_col <= '0;
            r_in_row <= '0;
            r_in_done <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_win <= '0;
        end else if (cfg_hit) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WIDTH:  r_cfg_width <= i_cfg_data[CFG_W_W-1:0];
                REG_HEIGHT: r_cfg_height <= i_cfg_data;
                default:    r_cfg_height <= r_cfg_height;
            endcase
            r_a_valid <= 1'b0;
            r_in_col <= '0;
            r_in_row <= '0;
            r_in_done <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_win <= '0;
        end else if (i_advance) begin
            r_a_valid <= i_valid;
            r_win <= n_win;
            if (n_win.last) begin
                // frame done: start over
                r_in_col <= '0;
                r_in_row <= '0;
                r_in_done <= 1'b0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
                r_in_done <= n_in_done;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_a_op <= t_opcode'(i_opcode);
            r_a_cell <= i_cell_in;
            if (wr && (r_in_col == '0)) begin
                r_col0[r_in_row[1:0]] <= r_a_cell;
            end
        end
    end

    assign o_ram_we = i_advance && wr;
    assign o_ram_wbank = r_in_row[1:0];
    assign o_ram_waddr = r_in_col;
    assign o_ram_wdata = r_a_cell;
    assign o_ram_raddr = right_ok ? out_col_p1[COL_W-1:0] : '0;
    assign o_col0 = r_col0;
    assign o_win = r_win;

`ifndef NO_ASSERTIONS
    a_done_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_done |-> (r_in_col == '0) && (r_in_row == '0))
        else $error("input counters not wrapped once frame is in");

    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_done |-> (r_out_row <= r_in_row))
        else $error("result row ahead of input row");

    a_bypass_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_advance && !cfg_hit && n_win.byp_hit) |-> $past(o_ram_we) && r_win.right_ok)
        else $error("line store bypass without a matching write");
`endif

endmodule

### rtl/core/bmf_window.sv
// bmf_window: 3x3 window columns, majority count and result register
// depends on bmf_pkg
module bmf_window
    import bmf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_win_ctl i_win,
    input  logic [3:0] i_rdata,
    input  logic [3:0] i_col0,
    output logic     o_valid,
    output logic     o_cell_out,
    output logic     o_frame_last
);

    logic [2:0] r_left;
    logic [2:0] r_mid;
    logic       r_out_valid;
    logic       r_cell;
    logic       r_last;

    logic [3:0] right4;
    logic [2:0] right3;
    logic [2:0] mid3;
    logic [2:0] rowmask;
    logic [8:0] bits;
    logic [8:0] mask;
    logic [3:0] rocks;
    logic [3:0] present;
    logic       result;

    always_comb begin
        right4 = i_rdata;
        // the write landing on the same edge as the read is not in the read data yet
        if (i_win.byp_hit) begin
            right4[i_win.byp_bank] = i_win.byp_bit;
        end
        right3 = pick3(right4, i_win.bank);
        mid3 = i_win.first_col ? pick3(i_col0, i_win.bank) : r_mid;
        rowmask = {i_win.bot_ok, 1'b1, i_win.top_ok};
        mask = {rowmask & {3{i_win.right_ok}}, rowmask, rowmask & {3{i_win.left_ok}}};
        bits = {right3, mid3, r_left} & mask;
        rocks = popcount9(bits);
        present = popcount9(mask);
        // rocks outnumber floors when twice the rocks exceed the cells present
        result = {rocks, 1'b0} > {1'b0, present};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_out_valid <= i_win.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_cell <= result;
            r_last <= i_win.last;
            if (i_win.valid) begin
                r_left <= mid3;
                r_mid <= right3;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_cell_out = r_cell;
    assign o_frame_last = r_last;

`ifndef NO_ASSERTIONS
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_win.valid && i_win.last) |-> (!i_win.bot_ok && !i_win.right_ok))
        else $error("frame end flagged away from the bottom right cell");

    a_first_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_win.valid |-> (i_win.first_col != i_win.left_ok))
        else $error("row start and left neighbour disagree");
`endif

endmodule

### rtl/core/binary_majority_filter_3x3.sv
// binary_majority_filter_3x3: top level, four row bank line stores, control and window
// depends on bmf_pkg, bmf_ram, bmf_ctrl, bmf_window
//
//  channel | direction | handshake             | payload
//  input   | in        | i_valid / o_stall     | i_opcode, i_cell_in
//  output  | out       | o_valid / i_stall     | o_cell_out, o_frame_last
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one cell per clock while i_stall does not hold a result; a transfer enters the input
// register, the counters and the line store read then load the window control register,
// and the result register is loaded from the window after that.
// a result leaves with the item that brings its lower right neighbour; drain items flush
// the last row.
// i_stall on a held result freezes the whole pipeline and raises o_stall.
// synchronous active low reset; the line stores need no clearing.
module binary_majority_filter_3x3
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH = C_MAX_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_opcode,
    input  logic             i_cell_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_cell_out,
    output logic             o_frame_last,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [ROW_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             advance;
    logic             ram_we;
    logic [1:0]       ram_wbank;
    logic [COL_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic [COL_W-1:0] ram_raddr;
    logic [3:0]       rdata;
    logic [3:0]       col0;
    t_win_ctl         win;

    assign advance = !(o_valid && i_stall);
    assign o_stall = !advance;
    assign o_cfg_ready = 1'b1;

    bmf_ctrl #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_valid     (i_valid),
        .i_opcode    (i_opcode),
        .i_cell_in   (i_cell_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_wbank (ram_wbank),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .o_col0      (col0),
        .o_win       (win)
    );

    // one line store per row modulo four
    for (genvar b = 0; b < 4; b++) begin : g_bank
        bmf_ram #(
            .WIDTH(1),
            .DEPTH(MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we && (ram_wbank == 2'(b))),
            .i_waddr (ram_waddr),
            .i_wdata (ram_wdata),
            .i_re    (advance),
            .i_raddr (ram_raddr),
            .o_rdata (rdata[b])
        );
    end

    bmf_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_win        (win),
        .i_rdata      (rdata),
        .i_col0       (col0),
        .o_valid      (o_valid),
        .o_cell_out   (o_cell_out),
        .o_frame_last (o_frame_last)
    );

endmodule
